### sv/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

    // Defaults for the top-level parameters.
    localparam int ENTRIES_DEFAULT    = 16;
    localparam int KEY_BITS_DEFAULT   = 64;
    localparam int VALUE_BITS_DEFAULT = 32;

    // Fixed field widths on the ports.
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Stream data widths, rounded up to whole bytes.
    localparam int S_DATA_W = ((KEY_W + VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((VALUE_W + 2 + 7) / 8) * 8;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_PUT = 1'b1
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
    } result_t;

    typedef enum logic {
        ST_MATCH,
        ST_COMMIT
    } back_state_t;

endpackage

`default_nettype wire

### sv/lkvc_front.sv
`default_nettype none

module lkvc_front
    import lkvc_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [0:0]          s_tuser,
    output logic                     q_valid,
    output item_t                    q_item,
    input  wire logic                q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    item_t            in_item;
    logic             push;

    // Decode the beat: the kind bit becomes the operation and key bits above
    // KEY_BITS are dropped so that they never take part in a match.
    always_comb begin
        in_item.func  = func_t'(s_tuser[0]);
        in_item.key   = KEY_W'(s_tdata[KEY_BITS-1:0]);
        in_item.value = s_tdata[KEY_W +: VALUE_W];
    end

    assign s_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    // The back end only pops a queue that holds something.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("lkvc_front: pop from an empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("lkvc_front: queue count above depth");

endmodule

`default_nettype wire

### sv/lkvc_back.sv
`default_nettype none

module lkvc_back
    import lkvc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEFAULT,
    parameter int KEY_BITS   = KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CAP_W-1:0] cap,
    input  wire logic             q_valid,
    input  wire item_t            q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output result_t               m_result
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Slot store; only slots below the occupancy count are meaningful.
    logic [KEY_BITS-1:0]   slot_key_reg  [ENTRIES];
    logic [VALUE_BITS-1:0] slot_data_reg [ENTRIES];
    logic [RANK_W-1:0]     slot_rank_reg [ENTRIES];
    logic [CNT_W-1:0]      occ_reg;

    back_state_t state_reg, state_next;

    // Item held between the match and the commit cycle.
    logic                  is_put_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [ENTRIES-1:0]    match_reg;
    logic [ENTRIES-1:0]    target_reg;
    logic [CNT_W-1:0]      thr_reg;
    logic                  hit_reg;
    logic                  evict_reg;
    logic                  insert_reg;
    logic [VALUE_W-1:0]    rd_reg;

    logic                  m_valid_reg;
    result_t               result_reg;

    logic [ENTRIES-1:0]    slot_valid;
    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    lru;
    logic [ENTRIES-1:0]    free_slot;
    logic [RANK_W-1:0]     hit_rank;
    logic [VALUE_BITS-1:0] hit_data;
    logic [CMP_W-1:0]      cap_eff;
    logic                  full;
    logic                  any_hit;
    logic                  is_put;
    logic                  do_insert;
    logic                  do_evict;
    logic [ENTRIES-1:0]    target;
    logic [CNT_W-1:0]      thr;
    logic                  commit;

    // Match cycle: compare the queue head against every slot at once and
    // pick the slot the operation will touch.
    always_comb begin
        hit_rank = '0;
        hit_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = (CNT_W'(i) < occ_reg);
            match[i]      = slot_valid[i] && (slot_key_reg[i] == KEY_BITS'(q_item.key));
            // Ranks of held slots run from 0 to occupancy-1, so the oldest
            // slot is the one whose rank is occupancy-1.
            lru[i]        = slot_valid[i] && (CNT_W'(slot_rank_reg[i]) == occ_reg - 1'b1);
            free_slot[i]  = (CNT_W'(i) == occ_reg);
            hit_rank      = hit_rank | (match[i] ? slot_rank_reg[i] : '0);
            hit_data      = hit_data | (match[i] ? slot_data_reg[i] : '0);
        end
    end

    always_comb begin
        if (cap == '0) begin
            cap_eff = CMP_W'(1);
        end else if (CMP_W'(cap) > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = CMP_W'(cap);
        end
    end

    assign full      = (CMP_W'(occ_reg) >= cap_eff);
    assign any_hit   = |match;
    assign is_put    = (q_item.func == FUNC_PUT);
    assign do_insert = is_put && !any_hit && !full;
    assign do_evict  = is_put && !any_hit && full;

    // Every held slot younger than the threshold ages by one. A fresh insert
    // ages them all, so its threshold is the occupancy itself.
    always_comb begin
        if (any_hit) begin
            target = match;
            thr    = CNT_W'(hit_rank);
        end else if (do_evict) begin
            target = lru;
            thr    = occ_reg - 1'b1;
        end else if (do_insert) begin
            target = free_slot;
            thr    = occ_reg;
        end else begin
            target = '0;
            thr    = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_MATCH: begin
                if (q_valid) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_MATCH;
                end
            end
            default: state_next = ST_MATCH;
        endcase
    end

    always_comb begin
        q_pop  = 1'b0;
        commit = 1'b0;
        unique case (state_reg)
            ST_MATCH:  q_pop  = q_valid;
            ST_COMMIT: commit = !m_valid_reg || m_ready;
            default: begin
                q_pop  = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_MATCH;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit && insert_reg) begin
                occ_reg <= occ_reg + 1'b1;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            is_put_reg <= is_put;
            key_reg    <= KEY_BITS'(q_item.key);
            value_reg  <= VALUE_BITS'(q_item.value);
            match_reg  <= match;
            target_reg <= target;
            thr_reg    <= thr;
            hit_reg    <= any_hit;
            evict_reg  <= do_evict;
            insert_reg <= do_insert;
            rd_reg     <= (any_hit && !is_put) ? VALUE_W'(hit_data) : '0;
        end
        if (commit) begin
            result_reg.hit        <= hit_reg;
            result_reg.read_value <= rd_reg;
            result_reg.evicted    <= evict_reg;
            for (int i = 0; i < ENTRIES; i++) begin
                if (target_reg[i]) begin
                    slot_rank_reg[i] <= '0;
                    if (is_put_reg) begin
                        slot_key_reg[i]  <= key_reg;
                        slot_data_reg[i] <= value_reg;
                    end
                end else if (slot_valid[i] && (CNT_W'(slot_rank_reg[i]) < thr_reg)) begin
                    slot_rank_reg[i] <= slot_rank_reg[i] + 1'b1;
                end
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    // Keys are never duplicated, so at most one slot can match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT) |-> $onehot0(match_reg))
        else $error("lkvc_back: key held in more than one slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(ENTRIES))
        else $error("lkvc_back: occupancy above the slot count");

    assert property (@(posedge aclk) disable iff (!aresetn) commit |=> m_valid_reg)
        else $error("lkvc_back: committed result not presented");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(result_reg.hit && result_reg.evicted))
        else $error("lkvc_back: hit and eviction flagged together");

endmodule

`default_nettype wire

### sv/lru_key_value_cache_core.sv
`default_nettype none

// Channel   Direction  Payload
// s_*       in         tdata: key [63:0], new_value [95:64]; tuser: func (0 get, 1 put)
// m_*       out        tdata: hit [0], read_value [32:1], evicted [33], zeros above
// cfg_*     in         active_capacity, written whenever cfg_wr_en is high
//
// Each beat passes through two back-end states: a match state compares the
// key against every slot in parallel and picks the slot to touch; a commit
// state then waits for the result register to be free and applies the recency
// update and the slot write. The back end works on one beat at a time.
// A two-beat queue lets the input keep accepting while the back end or an
// unread result holds it up. Reset empties the cache and sets the capacity
// to 16; no clearing pass is needed.

module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEFAULT,
    parameter int KEY_BITS   = KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Input beats.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // key, new_value
    input  wire logic [0:0]          s_tuser,  // func
    // Result beats.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,  // hit, read_value, evicted
    // Capacity register.
    input  wire logic                cfg_wr_en,
    input  wire logic [CAP_W-1:0]    cfg_wr_data
);

    logic [CAP_W-1:0] cap_reg;
    logic             q_valid;
    logic             q_pop;
    item_t            q_item;
    result_t          result;

    // The user must only change the capacity while the cache is idle (the block
    // does not enforce this), so that the back end can read it directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // The front end decodes beats and queues them.
    lkvc_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // The back end owns the slots, the recency ranks and the result register.
    lkvc_back #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cap      (cap_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = M_DATA_W'({result.evicted, result.read_value, result.hit});

endmodule

`default_nettype wire

### tb/lru_cache_checker.sv
`default_nettype none

// Watches both streams and the capacity port, keeps its own copy of the cache
// contents and recency order, and compares every result beat with the oldest
// expected one.
module lru_cache_checker
    import lkvc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [0:0]          s_tuser,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [M_DATA_W-1:0] m_tdata,
    input  wire logic                cfg_wr_en,
    input  wire logic [CAP_W-1:0]    cfg_wr_data,
    output int                       fail_count,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = ENTRIES_DEFAULT;

    logic [KEY_W-1:0]   cached_tag  [SLOTS];
    logic [VALUE_W-1:0] cached_word [SLOTS];
    int                 age         [SLOTS];
    int                 held = 0;
    logic [CAP_W-1:0]   capacity = CAP_RESET;
    result_t            expected_results [$];
    int                 mismatches = 0;

    // Slots that were younger than s grow one step older; s becomes age 0.
    function automatic void make_newest(int s);
        for (int i = 0; i < held; i++) begin
            if (age[i] < age[s]) begin
                age[i]++;
            end
        end
        age[s] = 0;
    endfunction

    function automatic result_t predict_access(func_t op, logic [KEY_W-1:0] k,
                                               logic [VALUE_W-1:0] v);
        result_t r;
        int      slot;
        int      room;
        int      victim;
        r    = '0;
        slot = -1;
        for (int i = 0; i < held; i++) begin
            if (slot < 0 && cached_tag[i] == k) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            r.hit = 1'b1;
            make_newest(slot);
            if (op == FUNC_PUT) begin
                cached_word[slot] = v;
            end else begin
                r.read_value = cached_word[slot];
            end
        end else if (op == FUNC_PUT) begin
            // A zero capacity behaves as one; anything above the slot count saturates.
            room = (capacity == '0) ? 1 : ((int'(capacity) > SLOTS) ? SLOTS : int'(capacity));
            if (held >= room) begin
                victim = 0;
                for (int i = 0; i < held; i++) begin
                    if (age[i] > age[victim]) begin
                        victim = i;
                    end
                end
                cached_tag[victim]  = k;
                cached_word[victim] = v;
                make_newest(victim);
                r.evicted = 1'b1;
            end else begin
                for (int i = 0; i < held; i++) begin
                    age[i]++;
                end
                cached_tag[held]  = k;
                cached_word[held] = v;
                age[held]         = 0;
                held++;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            held     = 0;
            capacity = CAP_RESET;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                capacity = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                got.hit        = m_tdata[0];
                got.read_value = m_tdata[VALUE_W:1];
                got.evicted    = m_tdata[VALUE_W+1];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result beat with nothing expected: hit %b value %h evicted %b",
                                 $time, got.hit, got.read_value, got.evicted);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit || got.read_value !== want.read_value ||
                        got.evicted !== want.evicted) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected hit %b value %h evicted %b, got hit %b value %h evicted %b",
                                     $time, want.hit, want.read_value, want.evicted,
                                     got.hit, got.read_value, got.evicted);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_access(func_t'(s_tuser[0]),
                                                          s_tdata[KEY_W-1:0],
                                                          s_tdata[KEY_W +: VALUE_W]));
            end
        end
        pending    <= expected_results.size();
        fail_count <= mismatches;
    end

endmodule

`default_nettype wire

### tb/tb_lru_key_value_cache_core.sv
`default_nettype none

// Stimulus and verdict for the LRU key/value cache. The checker beside the
// block does all prediction and comparison; this module only offers beats,
// plays the result receiver, writes the capacity register between phases and
// decides pass or fail at the end.
module tb_lru_key_value_cache_core;
    import lkvc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted beat before the run is declared hung. The
    // longest legitimate quiet stretch is the forced receiver hold-off below.
    localparam int IDLE_LIMIT = 2000;
    // Cycles to keep watching the result stream after the last expected beat,
    // enough to catch a stray extra result from the two-stage back end.
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 80;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_tvalid    = 1'b0;
    wire logic           s_tready;
    logic [S_DATA_W-1:0] s_tdata     = '0;   // key [63:0], new_value [95:64]
    logic [0:0]          s_tuser     = '0;   // func
    wire logic           m_tvalid;
    logic                m_tready    = 1'b0;
    wire [M_DATA_W-1:0]  m_tdata;            // hit [0], read_value [32:1], evicted [33]
    logic                cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data = '0;

    int               fail_count;
    int               pending;
    int               burst_left = 0;
    int               idle_cycles = 0;
    logic             hold_req   = 1'b0;
    logic             hold_done  = 1'b0;
    int               hold_left  = 0;
    logic [15:0]      rx_cycle   = '0;
    logic [KEY_W-1:0] key_pool [$];

    always #2 aclk = ~aclk;

    lru_key_value_cache_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lru_cache_checker cache_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Offer one input beat and return at the edge where it is taken. Beats
    // come in bursts of random length; between bursts the sender sometimes
    // drops tvalid for a random gap and sometimes goes straight on, so that
    // back-to-back stretches and gaps both land on every back-end phase.
    // tvalid is never lowered and raised in the same step.
    task automatic offer(input func_t op, input logic [KEY_W-1:0] k,
                         input logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, k};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every predicted result has come back.
    // The count from the checker is registered, so the task lets it update first.
    // Every beat yields exactly one result, so an empty count means the back
    // end has nothing left in flight.
    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // The capacity register is only written while the block is idle.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result receiver. It cycles through four stall patterns of its own:
    // always ready, mostly ready, coin flip and a short periodic stall. Once
    // the stimulus asks for it, it also holds off for a long stretch while
    // the sender keeps offering, which fills the internal queue and forces
    // s_tready low.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_cycle  <= '0;
            hold_left <= 0;
        end else begin
            rx_cycle <= rx_cycle + 16'd1;
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                case (rx_cycle[8:7])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                    2'd2: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (rx_cycle[2:0] != 3'd5);
                endcase
            end
        end
    end

    // Watchdog: a hung handshake on either side ends the run as a failure.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
        logic [CAP_W-1:0]   cap;
        func_t              op;
        int                 pool_size;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, first at the capacity that reset leaves behind.
        // A lookup on the empty cache, then the key and value extremes,
        // a put that updates a present key, and misses on other bit patterns.
        offer(FUNC_GET, '0, '1);
        offer(FUNC_PUT, '0, '1);
        offer(FUNC_PUT, '1, '0);
        offer(FUNC_GET, '1, '1);
        offer(FUNC_GET, '0, '0);
        offer(FUNC_PUT, '0, 32'h5A5A_A5A5);
        offer(FUNC_GET, '0, '0);
        offer(FUNC_GET, 64'h8000_0000_0000_0001, '0);
        offer(FUNC_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
        offer(FUNC_GET, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);

        // Lower the capacity below the three entries held: they stay and can hit,
        // and each put miss replaces exactly one least-recent entry.
        set_capacity(CAP_W'(2));
        offer(FUNC_GET, '1, '0);
        offer(FUNC_PUT, 64'h0000_0000_0000_1234, 32'h0000_0001);
        offer(FUNC_GET, '0, '0);
        offer(FUNC_PUT, '0, 32'h0000_0001);
        offer(FUNC_PUT, 64'h0000_0000_0000_0777, 32'h8000_0000);

        // A capacity of zero behaves as a capacity of one.
        set_capacity(CAP_W'(0));
        offer(FUNC_PUT, 64'h0000_0000_0000_DEAD, 32'hFFFF_0000);
        offer(FUNC_GET, 64'h0000_0000_0000_DEAD, '0);
        offer(FUNC_GET, {$urandom, $urandom}, $urandom);

        // Random phases. Keys mostly come from a small pool so that hits,
        // updates and evictions are all common; a few are fresh random keys.
        // The first phase uses a capacity above the slot count, which has to
        // saturate, and fills the cache. The second keeps that pool but drops
        // the capacity to three, well below the occupancy. Later phases use
        // the one-entry extreme, the full count, zero, and random settings.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: cap = CAP_W'(31);
                1: cap = CAP_W'(3);
                2: cap = CAP_W'(16);
                3: cap = CAP_W'(1);
                4: cap = CAP_W'(0);
                default: cap = CAP_W'($urandom_range(0, 31));
            endcase
            set_capacity(cap);
            if (p != 1) begin
                key_pool.delete();
                pool_size = (p == 0) ? 24 : $urandom_range(2, 24);
                repeat (pool_size) key_pool.push_back({$urandom, $urandom});
            end
            // Ask the receiver for its long hold-off once, in a full-size phase.
            if (p == 2) begin
                hold_req <= 1'b1;
            end
            repeat (60) begin
                if ($urandom_range(0, 15) == 0) begin
                    k = {$urandom, $urandom};
                end else begin
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end
                case ($urandom_range(0, 7))
                    0: v = '0;
                    1: v = '1;
                    default: v = $urandom;
                endcase
                op = ($urandom_range(0, 9) < 4) ? FUNC_GET : FUNC_PUT;
                offer(op, k, v);
            end
        end

        // Let every expected beat arrive, then watch a little longer for
        // anything extra before the verdict.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
